@@ rtl/rsa_modular_exponentiation_assert.svh @@
// assertion macros for the modular exponentiation block
// no dependencies
`ifndef RSA_MODULAR_EXPONENTIATION_ASSERT_SVH
`define RSA_MODULAR_EXPONENTIATION_ASSERT_SVH

// implication checked on every clock edge outside reset
`define RME_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

`endif

@@ rtl/rme_pkg.sv @@
// shared constants for the modular exponentiation block
// no dependencies
package rme_pkg;

  localparam int unsigned WordBits = 32;
  localparam int unsigned CfgIdxBits = 2;

  localparam logic [CfgIdxBits-1:0] RegModulus = 2'd0;
  localparam logic [CfgIdxBits-1:0] RegPubExp  = 2'd1;
  localparam logic [CfgIdxBits-1:0] RegPrivExp = 2'd2;

  localparam logic CmdEncrypt = 1'b0;
  localparam logic CmdDecrypt = 1'b1;

  localparam longint unsigned ModulusReset = 14;
  localparam longint unsigned PubExpReset  = 5;
  localparam longint unsigned PrivExpReset = 11;

endpackage

@@ rtl/rsa_modular_exponentiation.sv @@
// modular exponentiation: left-to-right square-and-multiply over bit-serial units
// (a modulus below 2 gives result 0 with no computation); the run time is set by the
// serial multiplier: a square and at most one multiply per exponent bit, an advance
// step per exponent bit, plus the input reduction
// one item at a time; the next item is taken once the block is back in idle after its result
// reset (async, active low) loads modulus 14, exponents 5 and 11 and empties the block
module rsa_modular_exponentiation #(
  parameter int unsigned WORD_BITS = rme_pkg::WordBits
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           cmd_i,
  input  logic [WORD_BITS-1:0]           message_value_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [WORD_BITS-1:0]           result_value_o,
  input  logic                           cfg_we_i,
  input  logic [rme_pkg::CfgIdxBits-1:0] cfg_idx_i,
  input  logic [WORD_BITS-1:0]           cfg_data_i
);
  localparam int unsigned CntBits = $clog2(WORD_BITS + 1);

  typedef enum logic [5:0] {
    StIdle = 6'b000001,
    StRed  = 6'b000010,
    StSq   = 6'b000100,
    StMul  = 6'b001000,
    StNext = 6'b010000,
    StOut  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [WORD_BITS-1:0] mod_q, pub_q, priv_q;
  logic [WORD_BITS-1:0] base_q, base_d, acc_q, acc_d, exp_q, exp_d, res_q, res_d;
  logic [WORD_BITS-1:0] mul_b;
  logic [CntBits-1:0]   bit_q, bit_d;
  logic                 cmd_q, cmd_d, red_start, mul_start, mul_first_q, mul_first_d;
  logic                 red_done, mul_done;
  logic [WORD_BITS-1:0] red_r, mul_r;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q  <= WORD_BITS'(rme_pkg::ModulusReset);
      pub_q  <= WORD_BITS'(rme_pkg::PubExpReset);
      priv_q <= WORD_BITS'(rme_pkg::PrivExpReset);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rme_pkg::RegModulus: mod_q  <= cfg_data_i;
        rme_pkg::RegPubExp:  pub_q  <= cfg_data_i;
        rme_pkg::RegPrivExp: priv_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // reduction starts on the accepting edge, straight from the input port
  rme_reduce #(.WordBits(WORD_BITS)) u_reduce (
    .clk_i, .rst_ni, .start_i(red_start), .x_i(message_value_i), .m_i(mod_q),
    .done_o(red_done), .r_o(red_r)
  );

  assign mul_b = (state_q == StSq) ? acc_q : base_q;
  rme_mulmod #(.WordBits(WORD_BITS)) u_mulmod (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(acc_q), .b_i(mul_b), .m_i(mod_q),
    .done_o(mul_done), .r_o(mul_r)
  );

  assign in_stall_o = (state_q != StIdle);
  assign out_valid_o = (state_q == StOut);
  assign result_value_o = res_q;

  // sequencer
  always_comb begin
    state_d = state_q;
    base_d = base_q; acc_d = acc_q; exp_d = exp_q; res_d = res_q;
    bit_d = bit_q; cmd_d = cmd_q;
    mul_first_d = 1'b0;
    red_start = 1'b0;
    mul_start = mul_first_q;
    unique case (state_q)
      StIdle: if (in_valid_i) begin
        cmd_d = cmd_i;
        if (mod_q < WORD_BITS'(2)) begin
          res_d = '0;
          state_d = StOut;
        end else begin
          state_d = StRed;
          red_start = 1'b1;
        end
      end
      StRed: begin
        if (red_done) begin
          base_d = red_r;
          acc_d  = WORD_BITS'(1);
          exp_d  = (cmd_q == rme_pkg::CmdDecrypt) ? priv_q : pub_q;
          bit_d  = CntBits'(WORD_BITS);
          mul_first_d = 1'b1;
          state_d = StSq;
        end
      end
      StSq: if (mul_done) begin
        acc_d = mul_r;
        if (exp_q[WORD_BITS-1]) begin
          mul_first_d = 1'b1;
          state_d = StMul;
        end else begin
          state_d = StNext;
        end
      end
      StMul: if (mul_done) begin
        acc_d = mul_r;
        state_d = StNext;
      end
      StNext: begin
        exp_d = {exp_q[WORD_BITS-2:0], 1'b0};
        bit_d = bit_q - 1'b1;
        if (bit_q == CntBits'(1)) begin
          res_d = acc_q;
          state_d = StOut;
        end else begin
          mul_first_d = 1'b1;
          state_d = StSq;
        end
      end
      StOut: if (!out_stall_i) begin
        state_d = StIdle;
        acc_d = '0; exp_d = '0; bit_d = '0;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      mul_first_q <= 1'b0;
      bit_q <= '0;
      exp_q <= '0;
      acc_q <= '0;
    end else begin
      state_q <= state_d;
      mul_first_q <= mul_first_d;
      bit_q <= bit_d;
      exp_q <= exp_d;
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    res_q <= res_d;
    cmd_q <= cmd_d;
  end
endmodule

@@ rtl/rme_mulmod.sv @@
// bit-serial modular multiplier: one double-and-add step per cycle
// depends on rme_pkg
module rme_mulmod #(
  parameter int unsigned WordBits = rme_pkg::WordBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [WordBits-1:0] a_i,
  input  logic [WordBits-1:0] b_i,
  input  logic [WordBits-1:0] m_i,
  output logic                done_o,
  output logic [WordBits-1:0] r_o
);
  localparam int unsigned CntBits = $clog2(WordBits + 1);

  logic [WordBits-1:0] r_q, r_d, b_q, b_d, a_q, a_d;
  logic [CntBits-1:0]  cnt_q, cnt_d;
  logic                busy_q, busy_d, done_q, done_d;
  logic [WordBits-1:0] r2, room;

  // add_mod helper: (x + y) mod m for x, y below m
  function automatic logic [WordBits-1:0] add_mod(
    input logic [WordBits-1:0] x, input logic [WordBits-1:0] y,
    input logic [WordBits-1:0] m);
    logic [WordBits-1:0] rm;
    rm = m - y;
    return (x >= rm) ? (x - rm) : (x + y);
  endfunction

  // one step: double then conditionally add, msb of b first
  always_comb begin
    r2     = add_mod(r_q, r_q, m_i);
    room   = add_mod(r2, a_q, m_i);
    r_d    = r_q;
    b_d    = b_q;
    a_d    = a_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      r_d    = '0;
      a_d    = a_i;
      b_d    = b_i;
      cnt_d  = CntBits'(WordBits);
      busy_d = 1'b1;
    end else if (busy_q) begin
      r_d   = b_q[WordBits-1] ? room : r2;
      b_d   = {b_q[WordBits-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntBits'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    r_q <= r_d;
    b_q <= b_d;
    a_q <= a_d;
  end

  assign done_o       = done_q;
  assign r_o          = r_q;
endmodule

@@ rtl/rme_reduce.sv @@
// bit-serial reduction of the input word modulo the modulus
// depends on rme_pkg
module rme_reduce #(
  parameter int unsigned WordBits = rme_pkg::WordBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [WordBits-1:0] x_i,
  input  logic [WordBits-1:0] m_i,
  output logic                done_o,
  output logic [WordBits-1:0] r_o
);
  localparam int unsigned CntBits = $clog2(WordBits + 1);

  logic [WordBits-1:0] r_q, r_d, x_q, x_d;
  logic [WordBits:0]   sh;
  logic [CntBits-1:0]  cnt_q, cnt_d;
  logic                busy_q, busy_d, done_q, done_d;

  // restoring remainder, one bit of x per cycle
  always_comb begin
    sh     = {r_q, x_q[WordBits-1]};
    r_d    = r_q;
    x_d    = x_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      r_d    = '0;
      x_d    = x_i;
      cnt_d  = CntBits'(WordBits);
      busy_d = 1'b1;
    end else if (busy_q) begin
      r_d   = (sh >= {1'b0, m_i}) ? WordBits'(sh - {1'b0, m_i}) : sh[WordBits-1:0];
      x_d   = {x_q[WordBits-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntBits'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
    x_q <= x_d;
  end

  assign done_o = done_q;
  assign r_o    = r_q;
endmodule

@@ rtl/rme_checker.sv @@
// port-level checker for the modular exponentiation block, bound to the top level
// depends on rsa_modular_exponentiation_assert.svh and rme_pkg
`include "rsa_modular_exponentiation_assert.svh"
module rme_checker #(
  parameter int unsigned WORD_BITS = rme_pkg::WordBits
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_stall_o,
  input logic                 out_valid_o,
  input logic                 out_stall_i,
  input logic [WORD_BITS-1:0] result_value_o
);
  // a held result keeps its value
  `RME_ASSERT(a_out_hold, clk_i, rst_ni,
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(result_value_o)))
  // no input accepted while a result waits
  `RME_ASSERT(a_one_at_a_time, clk_i, rst_ni, out_valid_o |-> in_stall_o)
  // an accepted item makes the block busy
  `RME_ASSERT(a_busy_after_accept, clk_i, rst_ni,
    (in_valid_i && !in_stall_o) |=> in_stall_o)
  // a result taken frees the input side
  `RME_ASSERT(a_free_after_out, clk_i, rst_ni,
    (out_valid_o && !out_stall_i) |=> !in_stall_o)
endmodule

bind rsa_modular_exponentiation rme_checker #(.WORD_BITS(WORD_BITS)) u_rme_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i, .result_value_o
);
